// File: hw/rtl/fvs_pkg.sv
// Shared types and constants for the four-voice square and noise synthesiser.
// Used by every module of the block; depends on nothing else.
package fvs_pkg;

    localparam int NUM_VOICES = 4;
    localparam int VOICE_W    = 2;
    localparam int OP_W       = 2;
    localparam int HZ_W       = 13;
    localparam int MS_W       = 14;
    localparam int PEAK_W     = 14;
    localparam int DUTY_W     = 8;
    localparam int NPER_W     = 8;
    localparam int SAMPLE_W   = 16;

    localparam int PHASE_W    = 16;
    localparam int LEVEL_W    = 14;
    localparam int ATTACK_W   = 10;
    localparam int RELEASE_W  = 9;
    localparam int REMAIN_W   = 18;
    localparam int LFSR_W     = 15;
    localparam int MIX_W      = 17;

    // Phase step = hz * 65536 / 16000 = floor(hz * 512 / 125), done as a
    // multiplication by a rounded-up reciprocal of 125 and a right shift.
    localparam int RECIP_W    = 23;
    localparam int PROD_W     = HZ_W + RECIP_W;
    localparam logic [RECIP_W-1:0] STEP_RECIP = 23'd4294968;
    localparam int STEP_SHIFT = 20;

    localparam logic [RELEASE_W-1:0] RELEASE_RESET   = 9'd40;
    localparam logic [LFSR_W-1:0]    LFSR_TAPS       = 15'h6000;
    localparam logic [LFSR_W-1:0]    LFSR_SEED       = 15'h7FFF;
    localparam logic [NPER_W-1:0]    NOISE_DIV_RESET = 8'd8;

    localparam logic signed [MIX_W-1:0] MIX_HI = 17'sd22000;
    localparam logic signed [MIX_W-1:0] MIX_LO = -17'sd22000;

    localparam logic [VOICE_W-1:0] NOISE_VOICE  = 2'd2;
    localparam logic [VOICE_W-1:0] EFFECT_VOICE = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_NOTE    = 2'd1,
        OP_SILENCE = 2'd2
    } t_op;

    // Settings that a note writes into one voice.
    typedef struct packed {
        logic [PHASE_W-1:0]   phase_step;
        logic [DUTY_W-1:0]    duty;
        logic [REMAIN_W-1:0]  remaining;
        logic [LEVEL_W-1:0]   target;
        logic [ATTACK_W-1:0]  attack;
        logic [RELEASE_W-1:0] release_rate;
    } t_note;

    // Per-voice strobes from the item decoder.
    typedef struct packed {
        logic note;
        logic silence;
        logic tick;
        logic force_zero;
        logic adv_phase;
    } t_voice_ctl;

endpackage

// File: hw/rtl/fvs_note_calc.sv
// Derives the per-voice note settings from the fields of a note item.
// Depends on fvs_pkg.
module fvs_note_calc (
    input  logic [fvs_pkg::HZ_W-1:0]   i_frequency_hz,
    input  logic [fvs_pkg::MS_W-1:0]   i_duration_ms,
    input  logic [fvs_pkg::PEAK_W-1:0] i_peak_level,
    input  logic [fvs_pkg::DUTY_W-1:0] i_duty,
    output fvs_pkg::t_note             o_note
);

    logic [fvs_pkg::PROD_W-1:0] step_prod;
    logic                       hz_zero;

    assign step_prod = fvs_pkg::PROD_W'(i_frequency_hz) * fvs_pkg::PROD_W'(fvs_pkg::STEP_RECIP);
    assign hz_zero   = (i_frequency_hz == '0);

    always_comb begin
        o_note.phase_step   = step_prod[fvs_pkg::STEP_SHIFT +: fvs_pkg::PHASE_W];
        o_note.duty         = i_duty;
        o_note.remaining    = {i_duration_ms, 4'b0000};
        o_note.target       = hz_zero ? '0 : i_peak_level;
        o_note.attack       = fvs_pkg::ATTACK_W'(i_peak_level[fvs_pkg::PEAK_W-1:5]) + 1'b1;
        o_note.release_rate = fvs_pkg::RELEASE_W'(i_peak_level[fvs_pkg::PEAK_W-1:6]) + 1'b1;
    end

endmodule

// File: hw/rtl/fvs_voice.sv
// One voice: note settings, envelope and square-wave phase accumulator.
// Depends on fvs_pkg.
module fvs_voice (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fvs_pkg::t_voice_ctl          i_ctl,
    input  fvs_pkg::t_note               i_note,
    output logic [fvs_pkg::LEVEL_W-1:0]  o_level,
    output logic                         o_square_hi
);

    logic [fvs_pkg::PHASE_W-1:0]   r_phase, n_phase;
    logic [fvs_pkg::PHASE_W-1:0]   r_step, n_step;
    logic [fvs_pkg::DUTY_W-1:0]    r_duty, n_duty;
    logic [fvs_pkg::LEVEL_W-1:0]   r_level, n_level;
    logic [fvs_pkg::LEVEL_W-1:0]   r_target, n_target;
    logic [fvs_pkg::ATTACK_W-1:0]  r_attack, n_attack;
    logic [fvs_pkg::RELEASE_W-1:0] r_release, n_release;
    logic [fvs_pkg::REMAIN_W-1:0]  r_rem, n_rem;

    logic [fvs_pkg::PHASE_W-1:0]   phase_sum;
    logic [fvs_pkg::LEVEL_W:0]     level_up;
    logic [fvs_pkg::LEVEL_W-1:0]   env_level;
    logic [fvs_pkg::REMAIN_W-1:0]  env_rem;

    assign phase_sum   = r_phase + r_step;
    assign level_up    = {1'b0, r_level} + (fvs_pkg::LEVEL_W + 1)'(r_attack);
    assign o_square_hi = (phase_sum[fvs_pkg::PHASE_W-1 -: fvs_pkg::DUTY_W] < r_duty);
    assign o_level     = i_ctl.force_zero ? '0 : env_level;

    // Attack while note samples remain, release once they run out.
    always_comb begin
        env_level = r_level;
        env_rem   = r_rem;
        if (r_rem != '0) begin
            env_rem = r_rem - 1'b1;
            if (r_level < r_target) begin
                env_level = (level_up > {1'b0, r_target}) ? r_target
                                                          : level_up[fvs_pkg::LEVEL_W-1:0];
            end
        end else if (r_level > fvs_pkg::LEVEL_W'(r_release)) begin
            env_level = r_level - fvs_pkg::LEVEL_W'(r_release);
        end else begin
            env_level = '0;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_step    = r_step;
        n_duty    = r_duty;
        n_level   = r_level;
        n_target  = r_target;
        n_attack  = r_attack;
        n_release = r_release;
        n_rem     = r_rem;
        if (i_ctl.note) begin
            n_step    = i_note.phase_step;
            n_duty    = i_note.duty;
            n_rem     = i_note.remaining;
            n_target  = i_note.target;
            n_attack  = i_note.attack;
            n_release = i_note.release_rate;
        end
        if (i_ctl.silence) begin
            n_target = '0;
            n_rem    = '0;
        end
        if (i_ctl.tick) begin
            n_level = env_level;
            n_rem   = env_rem;
            if (i_ctl.adv_phase && (env_level != '0)) begin
                n_phase = phase_sum;
            end
        end
        if (i_ctl.force_zero) begin
            n_level = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_step    <= '0;
            r_duty    <= '0;
            r_level   <= '0;
            r_target  <= '0;
            r_attack  <= '0;
            r_release <= fvs_pkg::RELEASE_RESET;
            r_rem     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_step    <= n_step;
            r_duty    <= n_duty;
            r_level   <= n_level;
            r_target  <= n_target;
            r_attack  <= n_attack;
            r_release <= n_release;
            r_rem     <= n_rem;
        end
    end

endmodule

// File: hw/rtl/fvs_noise.sv
// Noise source: 15-bit LFSR that shifts once every divider steps.
// Depends on fvs_pkg.
module fvs_noise (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_div_we,
    input  logic [fvs_pkg::NPER_W-1:0] i_div,
    input  logic                       i_step,
    output logic                       o_bit
);

    logic [fvs_pkg::LFSR_W-1:0] r_lfsr, n_lfsr;
    logic [fvs_pkg::NPER_W-1:0] r_div, n_div;
    logic [fvs_pkg::NPER_W-1:0] r_count, n_count;
    logic [fvs_pkg::NPER_W:0]   count_inc;
    logic                       shift;

    assign count_inc = {1'b0, r_count} + 1'b1;
    assign shift     = (count_inc >= {1'b0, r_div});
    assign o_bit     = n_lfsr[0];

    always_comb begin
        n_lfsr  = r_lfsr;
        n_count = r_count;
        n_div   = i_div_we ? i_div : r_div;
        if (i_step) begin
            if (shift) begin
                n_count = '0;
                n_lfsr  = (r_lfsr >> 1) ^ (r_lfsr[0] ? fvs_pkg::LFSR_TAPS : '0);
            end else begin
                n_count = count_inc[fvs_pkg::NPER_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr  <= fvs_pkg::LFSR_SEED;
            r_div   <= fvs_pkg::NOISE_DIV_RESET;
            r_count <= '0;
        end else begin
            r_lfsr  <= n_lfsr;
            r_div   <= n_div;
            r_count <= n_count;
        end
    end

endmodule

// File: hw/rtl/fvs_mix.sv
// Sums the four signed voice contributions and clamps to the output range.
// Depends on fvs_pkg.
module fvs_mix (
    input  logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::LEVEL_W-1:0] i_level,
    input  logic [fvs_pkg::NUM_VOICES-1:0]                       i_pos,
    output logic signed [fvs_pkg::SAMPLE_W-1:0]                  o_sample
);

    logic signed [fvs_pkg::MIX_W-1:0] term [fvs_pkg::NUM_VOICES];
    logic signed [fvs_pkg::MIX_W-1:0] sum;

    always_comb begin
        for (int k = 0; k < fvs_pkg::NUM_VOICES; k++) begin
            term[k] = i_pos[k] ? $signed(fvs_pkg::MIX_W'(i_level[k]))
                               : -$signed(fvs_pkg::MIX_W'(i_level[k]));
        end
        sum = term[0] + term[1] + term[2] + term[3];
        if (sum > fvs_pkg::MIX_HI) begin
            o_sample = fvs_pkg::SAMPLE_W'(fvs_pkg::MIX_HI);
        end else if (sum < fvs_pkg::MIX_LO) begin
            o_sample = fvs_pkg::SAMPLE_W'(fvs_pkg::MIX_LO);
        end else begin
            o_sample = sum[fvs_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

// File: hw/rtl/four_voice_square_noise_synth_top.sv
// Top level of the four-voice square and noise synthesiser.
// Depends on fvs_pkg, fvs_note_calc, fvs_voice, fvs_noise and fvs_mix.
//
//   Channel   Direction  Handshake                  Payload
//   in        sink       i_in_valid / o_in_ready    i_op, i_voice, i_frequency_hz,
//                                                   i_duration_ms, i_peak_level,
//                                                   i_duty, i_noise_period
//   out       source     o_out_valid / i_out_ready  o_sample
//   cfg       sink       i_cfg_we (no wait)         i_cfg_wdata (music enable)
//
// An accepted item is held in the input register until it executes; then the voice
// state is updated and, for a tick, the sample lands in the output register.
// A tick's sample thus passes the input register and then the output register.
// One item is taken every cycle as long as the sample register drains.
// Note and silence items never touch the output register, so they proceed
// even while a sample is waiting; only a tick behind a stalled sample waits.
// Reset is synchronous and active low; it restores every voice, the noise
// generator and the music enable, and leaves both registers empty.
module four_voice_square_noise_synth_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [fvs_pkg::OP_W-1:0]            i_op,
    input  logic [fvs_pkg::VOICE_W-1:0]         i_voice,
    input  logic [fvs_pkg::HZ_W-1:0]            i_frequency_hz,
    input  logic [fvs_pkg::MS_W-1:0]            i_duration_ms,
    input  logic [fvs_pkg::PEAK_W-1:0]          i_peak_level,
    input  logic [fvs_pkg::DUTY_W-1:0]          i_duty,
    input  logic [fvs_pkg::NPER_W-1:0]          i_noise_period,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [fvs_pkg::SAMPLE_W-1:0] o_sample,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata
);

    // Input register: the item waiting to be executed.
    logic                          r_in_valid;
    logic [fvs_pkg::OP_W-1:0]      r_op;
    logic [fvs_pkg::VOICE_W-1:0]   r_voice;
    logic [fvs_pkg::HZ_W-1:0]      r_frequency_hz;
    logic [fvs_pkg::MS_W-1:0]      r_duration_ms;
    logic [fvs_pkg::PEAK_W-1:0]    r_peak_level;
    logic [fvs_pkg::DUTY_W-1:0]    r_duty;
    logic [fvs_pkg::NPER_W-1:0]    r_noise_period;

    // Output register and configuration.
    logic                                r_out_valid;
    logic signed [fvs_pkg::SAMPLE_W-1:0] r_sample;
    logic                                r_music_en;

    logic is_tick, is_note, is_silence;
    logic exec_fire, in_accept;

    fvs_pkg::t_note     note;
    fvs_pkg::t_voice_ctl ctl [fvs_pkg::NUM_VOICES];
    logic [fvs_pkg::NUM_VOICES-1:0][fvs_pkg::LEVEL_W-1:0] level;
    logic [fvs_pkg::NUM_VOICES-1:0]                       square_hi;
    logic [fvs_pkg::NUM_VOICES-1:0]                       pos;
    logic                                                 noise_bit;
    logic signed [fvs_pkg::SAMPLE_W-1:0]                  mix_sample;

    assign is_tick    = (r_op == fvs_pkg::OP_TICK);
    assign is_note    = (r_op == fvs_pkg::OP_NOTE);
    assign is_silence = (r_op == fvs_pkg::OP_SILENCE);

    // A tick needs a free sample slot; every other item executes at once.
    assign exec_fire  = r_in_valid && (!is_tick || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec_fire;
    assign in_accept  = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    fvs_note_calc u_note_calc (
        .i_frequency_hz (r_frequency_hz),
        .i_duration_ms  (r_duration_ms),
        .i_peak_level   (r_peak_level),
        .i_duty         (r_duty),
        .o_note         (note)
    );

    // The effect voice always runs; the music voices run only while enabled
    // and are held at level zero otherwise.
    for (genvar k = 0; k < fvs_pkg::NUM_VOICES; k++) begin : g_voice
        localparam logic [fvs_pkg::VOICE_W-1:0] VID = fvs_pkg::VOICE_W'(k);
        localparam bit IS_EFFECT = (VID == fvs_pkg::EFFECT_VOICE);
        localparam bit IS_NOISE  = (VID == fvs_pkg::NOISE_VOICE);

        always_comb begin
            ctl[k].note       = exec_fire && is_note && (r_voice == VID);
            ctl[k].silence    = exec_fire && is_silence && (r_voice == VID);
            ctl[k].tick       = exec_fire && is_tick && (IS_EFFECT || r_music_en);
            ctl[k].force_zero = exec_fire && is_tick && !IS_EFFECT && !r_music_en;
            ctl[k].adv_phase  = !IS_NOISE;
        end

        fvs_voice u_voice (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl[k]),
            .i_note      (note),
            .o_level     (level[k]),
            .o_square_hi (square_hi[k])
        );

        assign pos[k] = IS_NOISE ? noise_bit : square_hi[k];
    end

    // The noise voice shifts its LFSR only on ticks where it sounds.
    fvs_noise u_noise (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_div_we (ctl[fvs_pkg::NOISE_VOICE].note),
        .i_div    (r_noise_period),
        .i_step   (ctl[fvs_pkg::NOISE_VOICE].tick && (level[fvs_pkg::NOISE_VOICE] != '0)),
        .o_bit    (noise_bit)
    );

    fvs_mix u_mix (
        .i_level  (level),
        .i_pos    (pos),
        .o_sample (mix_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_music_en  <= 1'b1;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (exec_fire) begin
                r_in_valid <= 1'b0;
            end
            if (exec_fire && is_tick) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_music_en <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op           <= i_op;
            r_voice        <= i_voice;
            r_frequency_hz <= i_frequency_hz;
            r_duration_ms  <= i_duration_ms;
            r_peak_level   <= i_peak_level;
            r_duty         <= i_duty;
            r_noise_period <= i_noise_period;
        end
        if (exec_fire && is_tick) begin
            r_sample <= mix_sample;
        end
    end

    // Every delivered sample lies inside the clamp range.
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_sample <= 16'sd22000) && (o_sample >= -16'sd22000)))
        else $error("sample outside clamp range");

    // An executed tick always leaves a sample in the output register.
    a_tick_gives_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && is_tick) |=> o_out_valid)
        else $error("tick executed without a sample");

    // A note, silence or unused code never fills an empty sample register.
    a_no_spurious_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(exec_fire && is_tick)) |=> !o_out_valid)
        else $error("sample appeared without a tick");

    // A tick never overwrites a sample that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && is_tick) |-> (!r_out_valid || i_out_ready))
        else $error("waiting sample overwritten");

    // Reset leaves the output register empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("sample valid after reset");

endmodule
